// ===== design/mst_pkg.sv =====
package mst_pkg;

  // one input word: wake flag, three axis samples and the current time
  typedef struct packed {
    logic               wake_event;
    logic signed [11:0] acc_x;
    logic signed [11:0] acc_y;
    logic signed [11:0] acc_z;
    logic [31:0]        now_ds;
  } in_word_t;

  // one report word
  typedef struct packed {
    logic [7:0]  speed;
    logic [13:0] interval_ms;
    logic        still_moving;
    logic        last_report;
  } out_word_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_END_DELAY  = 2'd1;
  localparam logic [1:0] REG_MOVING_INT = 2'd2;
  localparam logic [1:0] REG_SLEEP_INT  = 2'd3;

  localparam logic [10:0] THRESHOLD_RST  = 11'd15;
  localparam logic [15:0] END_DELAY_RST  = 16'd450;
  localparam logic [13:0] MOVING_INT_RST = 14'd100;
  localparam logic [13:0] SLEEP_INT_RST  = 14'd1000;

  // arithmetic constants
  localparam logic signed [16:0] TICK_DS    = 17'sd1;
  localparam logic [31:0]        RECENT_DS  = 32'd40;
  localparam logic [7:0]         SPEED_MAX  = 8'd250;
  localparam logic [33:0]        DIV10_MUL  = 34'd52429;  // 2^19 / 10, rounded up
  localparam int                 DIV10_SHR  = 19;
  localparam logic [31:0]        ROOT_BIT0  = 32'h4000_0000;

  // axis select codes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // jump conditions
  localparam logic [2:0] CND_NONE     = 3'd0;
  localparam logic [2:0] CND_NO_INPUT = 3'd1;
  localparam logic [2:0] CND_NOT_MOV  = 3'd2;
  localparam logic [2:0] CND_ROOT_MORE = 3'd3;
  localparam logic [2:0] CND_OUT_BUSY = 3'd4;
  localparam logic [2:0] CND_NOT_END  = 3'd5;

  // program step addresses
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHKMV  = 4'd1;
  localparam logic [3:0] ST_VX     = 4'd2;
  localparam logic [3:0] ST_VY     = 4'd3;
  localparam logic [3:0] ST_VZ     = 4'd4;
  localparam logic [3:0] ST_SQX    = 4'd5;
  localparam logic [3:0] ST_SQY    = 4'd6;
  localparam logic [3:0] ST_SQZ    = 4'd7;
  localparam logic [3:0] ST_RTINIT = 4'd8;
  localparam logic [3:0] ST_RTSTEP = 4'd9;
  localparam logic [3:0] ST_SPEED  = 4'd10;
  localparam logic [3:0] ST_EMIT1  = 4'd11;
  localparam logic [3:0] ST_CHKEND = 4'd12;
  localparam logic [3:0] ST_CLEAR  = 4'd13;
  localparam logic [3:0] ST_SPEED0 = 4'd14;
  localparam logic [3:0] ST_EMIT2  = 4'd15;

  // control word
  typedef struct packed {
    logic [2:0] cond;
    logic [3:0] target;
    logic       accept;
    logic       acc_clr;
    logic       vel_en;
    logic       sq_en;
    logic [1:0] axis;
    logic       rt_init;
    logic       rt_step;
    logic       spd_en;
    logic       zero_root;
    logic       restamp;
    logic       emit;
    logic       end_rep;
    logic       clear;
  } ctrl_t;

  // status from the datapath
  typedef struct packed {
    logic moving;
    logic rt_more;
    logic ending;
  } dp_stat_t;

  // everything the sequencer branches on
  typedef struct packed {
    logic in_valid;
    logic moving;
    logic rt_more;
    logic out_busy;
    logic ending;
  } flags_t;

  // microprogram; the last step falls through to step 0 as the counter wraps
  function automatic ctrl_t mst_rom(input logic [3:0] addr);
    ctrl_t w;
    w = '0;
    case (addr)
      ST_IDLE: begin
        w.accept = 1'b1;
        w.cond   = CND_NO_INPUT;
        w.target = ST_IDLE;
      end
      ST_CHKMV: begin
        w.acc_clr = 1'b1;
        w.cond    = CND_NOT_MOV;
        w.target  = ST_IDLE;
      end
      ST_VX: begin
        w.vel_en = 1'b1;
        w.axis   = AX_X;
      end
      ST_VY: begin
        w.vel_en = 1'b1;
        w.axis   = AX_Y;
      end
      ST_VZ: begin
        w.vel_en = 1'b1;
        w.axis   = AX_Z;
      end
      ST_SQX: begin
        w.sq_en = 1'b1;
        w.axis  = AX_X;
      end
      ST_SQY: begin
        w.sq_en = 1'b1;
        w.axis  = AX_Y;
      end
      ST_SQZ: begin
        w.sq_en = 1'b1;
        w.axis  = AX_Z;
      end
      ST_RTINIT: begin
        w.rt_init = 1'b1;
      end
      ST_RTSTEP: begin
        w.rt_step = 1'b1;
        w.cond    = CND_ROOT_MORE;
        w.target  = ST_RTSTEP;
      end
      ST_SPEED: begin
        w.spd_en  = 1'b1;
        w.restamp = 1'b1;
      end
      ST_EMIT1: begin
        w.emit   = 1'b1;
        w.cond   = CND_OUT_BUSY;
        w.target = ST_EMIT1;
      end
      ST_CHKEND: begin
        w.cond   = CND_NOT_END;
        w.target = ST_IDLE;
      end
      ST_CLEAR: begin
        w.clear = 1'b1;
      end
      ST_SPEED0: begin
        w.spd_en    = 1'b1;
        w.zero_root = 1'b1;
      end
      ST_EMIT2: begin
        w.emit    = 1'b1;
        w.end_rep = 1'b1;
        w.cond    = CND_OUT_BUSY;
        w.target  = ST_EMIT2;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/mst_seq.sv =====
module mst_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  mst_pkg::flags_t flags,
  output mst_pkg::ctrl_t  ctrl
);

  logic [3:0] pc_r;
  logic [3:0] pc_nxt;
  logic       take;

  assign ctrl = mst_pkg::mst_rom(pc_r);

  always_comb begin
    case (ctrl.cond)
      mst_pkg::CND_NONE:      take = 1'b0;
      mst_pkg::CND_NO_INPUT:  take = !flags.in_valid;
      mst_pkg::CND_NOT_MOV:   take = !flags.moving;
      mst_pkg::CND_ROOT_MORE: take = flags.rt_more;
      mst_pkg::CND_OUT_BUSY:  take = flags.out_busy;
      mst_pkg::CND_NOT_END:   take = !flags.ending;
      default:                take = 1'b0;
    endcase
    pc_nxt = take ? ctrl.target : pc_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= mst_pkg::ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== design/mst_dp.sv =====
module mst_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  mst_pkg::ctrl_t    ctrl,
  input  logic              in_fire,
  input  mst_pkg::in_word_t in_word,
  input  logic [10:0]       threshold,
  input  logic [15:0]       end_delay,
  output mst_pkg::dp_stat_t stat,
  output logic [7:0]        speed
);

  // captured sample
  logic signed [11:0] acc_r [0:2];
  logic [31:0]        now_r;

  // tracker state
  logic signed [15:0] vel_r [0:2];
  logic signed [15:0] vel_nxt;
  logic               moving_r;
  logic [31:0]        last_r;

  // sum of squares and root unit
  logic [31:0] sum_r;
  logic [31:0] x_r;
  logic [31:0] res_r;
  logic [31:0] bit_r;
  logic [7:0]  speed_r;
  logic [7:0]  speed_nxt;

  logic signed [16:0] t_sum;
  logic [16:0]        t_mag;
  logic [33:0]        prod;
  logic [15:0]        quot;
  logic [15:0]        v_mag;
  logic [31:0]        sq;
  logic [31:0]        trial;
  logic [31:0]        root;
  logic [31:0]        recent;
  logic               over;

  // shared divide-by-ten: reciprocal multiply, exact for these magnitudes
  always_comb begin
    t_sum   = 17'(vel_r[ctrl.axis]) + 17'(acc_r[ctrl.axis]) * mst_pkg::TICK_DS;
    t_mag   = t_sum[16] ? 17'(-t_sum) : 17'(t_sum);
    prod    = {17'b0, t_mag} * mst_pkg::DIV10_MUL;
    quot    = 16'(prod[33:mst_pkg::DIV10_SHR]);
    vel_nxt = t_sum[16] ? -$signed(quot) : $signed(quot);
  end

  // square of one axis velocity
  always_comb begin
    v_mag = vel_r[ctrl.axis][15] ? 16'(-vel_r[ctrl.axis]) : 16'(vel_r[ctrl.axis]);
    sq    = {16'b0, v_mag} * {16'b0, v_mag};
  end

  assign trial = res_r + bit_r;

  // clamp and recent-movement rule
  always_comb begin
    root   = ctrl.zero_root ? 32'd0 : res_r;
    recent = last_r + mst_pkg::RECENT_DS;
    speed_nxt = (root > 32'(mst_pkg::SPEED_MAX)) ? mst_pkg::SPEED_MAX : root[7:0];
    if (recent > now_r) begin
      if (speed_nxt == 8'd0) begin
        speed_nxt = 8'd1;
      end
    end else if (recent < now_r) begin
      speed_nxt = 8'd0;
    end
  end

  assign over = ($signed({acc_r[0][11], acc_r[0]}) > $signed({2'b00, threshold}))
             || ($signed({acc_r[1][11], acc_r[1]}) > $signed({2'b00, threshold}))
             || ($signed({acc_r[2][11], acc_r[2]}) > $signed({2'b00, threshold}));

  // sample registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc_r[0] <= in_word.acc_x;
      acc_r[1] <= in_word.acc_y;
      acc_r[2] <= in_word.acc_z;
      now_r    <= in_word.now_ds;
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r[0] <= '0;
      vel_r[1] <= '0;
      vel_r[2] <= '0;
      moving_r <= 1'b1;
      last_r   <= '0;
    end else begin
      if (in_fire && in_word.wake_event) begin
        moving_r <= 1'b1;
        last_r   <= in_word.now_ds;
      end
      if (ctrl.vel_en) begin
        vel_r[ctrl.axis] <= vel_nxt;
      end
      if (ctrl.restamp && over) begin
        last_r <= now_r;
      end
      if (ctrl.clear) begin
        vel_r[0] <= '0;
        vel_r[1] <= '0;
        vel_r[2] <= '0;
        moving_r <= 1'b0;
        last_r   <= '0;
      end
    end
  end

  // sum of squares, bit-pair square root, speed
  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      sum_r <= '0;
    end else if (ctrl.sq_en) begin
      sum_r <= sum_r + sq;
    end
    if (ctrl.rt_init) begin
      x_r   <= sum_r;
      res_r <= '0;
      bit_r <= mst_pkg::ROOT_BIT0;
    end else if (ctrl.rt_step) begin
      if (x_r >= trial) begin
        x_r   <= x_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (ctrl.spd_en) begin
      speed_r <= speed_nxt;
    end
  end

  assign stat.moving  = moving_r;
  assign stat.rt_more = (bit_r != 32'd1);
  assign stat.ending  = ((last_r + {16'b0, end_delay}) < now_r);
  assign speed        = speed_r;

endmodule

// ===== design/motion_speed_tracker.sv =====
// motion and speed tracker, one timer tick per input word
//
// in channel (in_valid/in_ready/in_data): wake flag, x/y/z acceleration in
// signed milli-g and the current decisecond time. out channel
// (out_valid/out_ready/out_data): reports of speed, interval, moving flag and
// a last-of-tick marker. a tick gives no report while not moving, one report
// while moving, and two when movement ends on that tick.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): threshold, end delay
// and the two intervals; cfg_ready is always high, write only while idle.
//
// sequence: a short microprogram walks each word; the 16-step square root
// dominates. a tick that reports puts its report word out at the first
// emit step, after the root and speed steps, and an ending tick its second
// word after the clear and zero-speed steps; the next word is taken at
// idle, also after a word that stops at the not-moving check.
// the result sits in an output register, so the next word is taken while a
// report waits; when the receiver stalls and a new report is due, the
// program holds at its emit step until the register frees up.
// reset: moving set, velocities and stamp cleared, registers at defaults.
module motion_speed_tracker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mst_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mst_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // configuration registers
  logic [10:0] thr_r;
  logic [15:0] end_delay_r;
  logic [13:0] mov_int_r;
  logic [13:0] slp_int_r;

  // output register
  logic               out_valid_r;
  logic               out_valid_nxt;
  mst_pkg::out_word_t out_data_r;
  mst_pkg::out_word_t out_data_nxt;

  mst_pkg::ctrl_t    ctrl;
  mst_pkg::flags_t   flags;
  mst_pkg::dp_stat_t stat;
  logic [7:0]        speed;
  logic              in_fire;
  logic              out_busy;
  logic              out_load;

  assign in_ready  = ctrl.accept;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // emit waits while a held word is not being taken
  assign out_busy = out_valid_r && !out_ready;
  assign out_load = ctrl.emit && !out_busy;

  assign flags.in_valid = in_valid;
  assign flags.moving   = stat.moving;
  assign flags.rt_more  = stat.rt_more;
  assign flags.out_busy = out_busy;
  assign flags.ending   = stat.ending;

  mst_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  mst_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_fire   (in_fire),
    .in_word   (in_data),
    .threshold (thr_r),
    .end_delay (end_delay_r),
    .stat      (stat),
    .speed     (speed)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= mst_pkg::THRESHOLD_RST;
      end_delay_r <= mst_pkg::END_DELAY_RST;
      mov_int_r   <= mst_pkg::MOVING_INT_RST;
      slp_int_r   <= mst_pkg::SLEEP_INT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mst_pkg::REG_THRESHOLD:  thr_r       <= cfg_data[10:0];
        mst_pkg::REG_END_DELAY:  end_delay_r <= cfg_data;
        mst_pkg::REG_MOVING_INT: mov_int_r   <= cfg_data[13:0];
        mst_pkg::REG_SLEEP_INT:  slp_int_r   <= cfg_data[13:0];
        default: begin
        end
      endcase
    end
  end

  // report word: moving report ends the tick unless movement ends too
  always_comb begin
    out_data_nxt.speed        = speed;
    out_data_nxt.interval_ms  = ctrl.end_rep ? slp_int_r : mov_int_r;
    out_data_nxt.still_moving = !ctrl.end_rep;
    out_data_nxt.last_report  = ctrl.end_rep || !stat.ending;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a report never overwrites a word still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_busy |=> !$changed(out_data_r) || !out_valid_r)
    else $error("held report overwritten");

  // reported speed stays in range
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.speed <= mst_pkg::SPEED_MAX)
    else $error("speed above clamp");

  // an end-of-movement report leaves the tracker not moving
  a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && ctrl.end_rep) |-> !stat.moving)
    else $error("end report while still moving");

  // no word is taken while a tick is in progress
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.vel_en || ctrl.rt_step || ctrl.emit) |-> !in_ready)
    else $error("input taken mid-tick");

endmodule
